[hdl/skf_pkg.sv]
// ----------------------------------------------------------------------------
// skf_pkg: shared types, constants and fixed-point helpers
// Operation codes, controller states, command/status bundles and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

  localparam int DATA_W    = 32;
  localparam int VAR_W     = 31;
  localparam int PROD_W    = 64;
  localparam int IDX_W     = 3;
  localparam int FRAC_BITS = 16;

  localparam logic signed [PROD_W-1:0] VAL_MAX = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
  localparam logic signed [PROD_W-1:0] VAL_MIN = -VAL_MAX - 64'sd1;

  typedef enum logic [IDX_W-1:0] {
    REG_INIT_EST  = 3'd0,
    REG_INIT_VAR  = 3'd1,
    REG_PROC_NSE  = 3'd2,
    REG_MEAS_NSE  = 3'd3,
    REG_STATE_GN  = 3'd4,
    REG_MEAS_GN   = 3'd5
  } reg_idx_e;

  typedef enum logic [3:0] {
    OP_X_PRED,
    OP_P_A1,
    OP_P_PRED,
    OP_HP,
    OP_DEN,
    OP_HX,
    OP_KR,
    OP_KH,
    OP_P_UPD
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_WB,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_FIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    op_e  op;
    logic load_in;
    logic mul;
    logic wb;
    logic div_init;
    logic div_step;
    logic div_fin;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic den_pos;
    logic div_last;
  } status_t;

  // Clamp to the signed data range.
  function automatic logic signed [DATA_W-1:0] sat_val(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > VAL_MAX) begin
      r = VAL_MAX[DATA_W-1:0];
    end else if (v < VAL_MIN) begin
      r = VAL_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // Clamp to the non-negative variance range.
  function automatic logic [VAR_W-1:0] sat_var(input logic signed [PROD_W-1:0] v);
    logic [VAR_W-1:0] r;
    if (v > VAL_MAX) begin
      r = VAL_MAX[VAR_W-1:0];
    end else if (v < 64'sd0) begin
      r = '0;
    end else begin
      r = v[VAR_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/skf_ctrl.sv]
// ----------------------------------------------------------------------------
// skf_ctrl: sequencing controller
// Steps the datapath through prediction, gain division and correction.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  input  wire skf_pkg::status_t status_i,
  output skf_pkg::cmd_t        cmd_o
);
  import skf_pkg::*;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_X_PRED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    op_d           = op_q;
    cmd_o          = '0;
    cmd_o.op       = op_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          op_d          = OP_X_PRED;
          state_d       = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_WB;
      end
      ST_WB: begin
        cmd_o.wb = 1'b1;
        unique case (op_q)
          OP_X_PRED: begin op_d = OP_P_A1;   state_d = ST_MUL; end
          OP_P_A1:   begin op_d = OP_P_PRED; state_d = ST_MUL; end
          OP_P_PRED: begin op_d = OP_HP;     state_d = ST_MUL; end
          OP_HP:     begin op_d = OP_DEN;    state_d = ST_MUL; end
          OP_DEN:    begin                   state_d = ST_DIV_INIT; end
          OP_HX:     begin op_d = OP_KR;     state_d = ST_MUL; end
          OP_KR:     begin op_d = OP_KH;     state_d = ST_MUL; end
          OP_KH:     begin op_d = OP_P_UPD;  state_d = ST_MUL; end
          OP_P_UPD:  begin                   state_d = ST_OUT; end
          default:   begin                   state_d = ST_IDLE; end
        endcase
      end
      ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        if (status_i.den_pos) begin
          state_d = ST_DIV;
        end else begin
          op_d    = OP_HX;
          state_d = ST_MUL;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_DIV_FIN;
        end
      end
      ST_DIV_FIN: begin
        cmd_o.div_fin = 1'b1;
        op_d          = OP_HX;
        state_d       = ST_MUL;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[hdl/skf_datapath.sv]
// ----------------------------------------------------------------------------
// skf_datapath: shared multiplier, restoring divider and filter registers
// Holds configuration, filter state, temporaries and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_datapath #(
  parameter int FracBits = skf_pkg::FRAC_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire skf_pkg::cmd_t                 cmd_i,
  output skf_pkg::status_t                   status_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [skf_pkg::IDX_W-1:0]     cfg_idx_i,
  input  wire logic [skf_pkg::DATA_W-1:0]    cfg_data_i,
  input  wire logic signed [skf_pkg::DATA_W-1:0] measurement_i,
  output logic signed [skf_pkg::DATA_W-1:0]  estimate_o,
  output logic signed [skf_pkg::DATA_W-1:0]  gain_o,
  output logic [skf_pkg::VAR_W-1:0]          variance_o
);
  import skf_pkg::*;

  localparam int DivW = DATA_W + FracBits;
  localparam int CntW = $clog2(DivW);
  localparam logic signed [PROD_W-1:0] OneFx = 64'sd1 <<< FracBits;

  // configuration
  logic signed [DATA_W-1:0] a_q, h_q;
  logic [VAR_W-1:0]         q_q, r_q;

  // filter state and temporaries
  logic signed [DATA_W-1:0] x_q, z_q, tmp_q, hp_q, den_q, k_q;
  logic [VAR_W-1:0]         p_q;
  logic signed [PROD_W-1:0] prod_q;

  // divider
  logic [DivW-1:0]          dvd_q;
  logic [DATA_W-1:0]        rem_q;
  logic                     neg_q;
  logic [CntW-1:0]          cnt_q;

  // result register
  logic signed [DATA_W-1:0] est_out_q, gain_out_q;
  logic [VAR_W-1:0]         var_out_q;

  logic signed [DATA_W-1:0] op_a, op_b, fx;
  logic signed [PROD_W-1:0] shifted, quo_s;
  logic [DATA_W-1:0]        rem_sh, hp_abs;
  logic [DATA_W:0]          trial;

  assign status_o.den_pos  = !den_q[DATA_W-1] && (den_q != '0);
  assign status_o.div_last = (cnt_q == CntW'(DivW - 1));

  always_comb begin
    unique case (cmd_i.op)
      OP_X_PRED: begin op_a = a_q;   op_b = x_q; end
      OP_P_A1:   begin op_a = a_q;   op_b = DATA_W'(p_q); end
      OP_P_PRED: begin op_a = tmp_q; op_b = a_q; end
      OP_HP:     begin op_a = DATA_W'(p_q); op_b = h_q; end
      OP_DEN:    begin op_a = hp_q;  op_b = h_q; end
      OP_HX:     begin op_a = h_q;   op_b = x_q; end
      OP_KR:     begin op_a = k_q;   op_b = tmp_q; end
      OP_KH:     begin op_a = k_q;   op_b = h_q; end
      OP_P_UPD:  begin op_a = tmp_q; op_b = DATA_W'(p_q); end
      default:   begin op_a = '0;    op_b = '0; end
    endcase
  end

  // floor shift then clamp
  assign shifted = prod_q >>> FracBits;
  assign fx      = sat_val(shifted);

  assign rem_sh  = {rem_q[DATA_W-2:0], dvd_q[DivW-1]};
  assign trial   = {1'b0, rem_sh} - {1'b0, den_q};
  assign hp_abs  = hp_q[DATA_W-1] ? DATA_W'(-hp_q) : DATA_W'(hp_q);
  assign quo_s   = neg_q ? -PROD_W'(dvd_q) : PROD_W'(dvd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q        <= '0;
      r_q        <= VAR_W'(OneFx);
      a_q        <= DATA_W'(OneFx);
      h_q        <= DATA_W'(OneFx);
      x_q        <= '0;
      p_q        <= VAR_W'(OneFx);
      cnt_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_INIT_EST: x_q <= cfg_data_i;
          REG_INIT_VAR: p_q <= cfg_data_i[VAR_W-1:0];
          REG_PROC_NSE: q_q <= cfg_data_i[VAR_W-1:0];
          REG_MEAS_NSE: r_q <= cfg_data_i[VAR_W-1:0];
          REG_STATE_GN: a_q <= cfg_data_i;
          REG_MEAS_GN:  h_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.wb) begin
        unique case (cmd_i.op)
          OP_X_PRED: x_q <= fx;
          OP_P_A1:   ;
          OP_P_PRED: p_q <= sat_var(PROD_W'(fx) + PROD_W'($signed({1'b0, q_q})));
          OP_HP:     ;
          OP_DEN:    ;
          OP_HX:     ;
          OP_KR:     x_q <= sat_val(PROD_W'(x_q) + PROD_W'(fx));
          OP_KH:     ;
          OP_P_UPD:  p_q <= sat_var(PROD_W'(fx));
          default:   ;
        endcase
      end
      if (cmd_i.div_init) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  // unreset payload path
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      z_q <= measurement_i;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
    end
    if (cmd_i.wb) begin
      unique case (cmd_i.op)
        OP_X_PRED: ;
        OP_P_A1:   tmp_q <= fx;
        OP_P_PRED: ;
        OP_HP:     hp_q  <= fx;
        OP_DEN:    den_q <= sat_val(PROD_W'(fx) + PROD_W'($signed({1'b0, r_q})));
        OP_HX:     tmp_q <= sat_val(PROD_W'(z_q) - PROD_W'(fx));
        OP_KR:     ;
        OP_KH:     tmp_q <= sat_val(OneFx - PROD_W'(fx));
        OP_P_UPD:  ;
        default:   ;
      endcase
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      dvd_q <= {hp_abs, {FracBits{1'b0}}};
      neg_q <= hp_q[DATA_W-1];
      if (!status_o.den_pos) begin
        k_q <= '0;
      end
    end
    if (cmd_i.div_step) begin
      if (!trial[DATA_W]) begin
        rem_q <= trial[DATA_W-1:0];
        dvd_q <= {dvd_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        dvd_q <= {dvd_q[DivW-2:0], 1'b0};
      end
    end
    if (cmd_i.div_fin) begin
      k_q <= sat_val(quo_s);
    end
    if (cmd_i.commit) begin
      est_out_q  <= x_q;
      gain_out_q <= k_q;
      var_out_q  <= p_q;
    end
  end

  assign estimate_o = est_out_q;
  assign gain_o     = gain_out_q;
  assign variance_o = var_out_q;

endmodule

`default_nettype wire

[hdl/scalar_kalman_filter_core.sv]
// ----------------------------------------------------------------------------
// scalar_kalman_filter_core: one-dimensional Kalman filter, signed fixed point
// Q16.16 by default; a 1-bit-a-cycle restoring divider forms the gain, which is
// 0 if its divisor is not positive. Inputs wait for the last result to commit,
// so output stalls hold them off. Reset idles the core and restores the defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter_core #(
  parameter int FracBits = skf_pkg::FRAC_BITS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [skf_pkg::IDX_W-1:0]         cfg_idx_i,
  input  wire logic [skf_pkg::DATA_W-1:0]        cfg_data_i,
  // measurement channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [skf_pkg::DATA_W-1:0] measurement_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [skf_pkg::DATA_W-1:0]      estimate_o,
  output logic signed [skf_pkg::DATA_W-1:0]      gain_o,
  output logic [skf_pkg::VAR_W-1:0]              variance_o
);
  import skf_pkg::*;

  // Reset returns the configuration and filter state to their defaults
  // (A = H = r = 1.0, q = 0, starting estimate 0, starting variance 1.0) and
  // the controller to idle with no result pending. Writing the starting
  // estimate or variance reloads the live filter state at once.

  cmd_t    cmd;
  status_t status;

  // Controller: accept a measurement, run nine shared-multiplier operations
  // (each a product state, then a write-back state), the restoring division
  // for a positive gain divisor in between, then commit the result register.
  // Hold the commit while a previous result still sits unaccepted on the output.
  skf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: one 32x32 multiplier with a product register, floor shift and
  // saturating add on write-back, a divider producing one quotient bit a
  // cycle, and the registered result.
  skf_datapath #(
    .FracBits (FracBits)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .measurement_i (measurement_i),
    .estimate_o    (estimate_o),
    .gain_o        (gain_o),
    .variance_o    (variance_o)
  );

endmodule

`default_nettype wire

[hdl/skf_checker.sv]
// ----------------------------------------------------------------------------
// skf_checker: port-level checks for the Kalman filter core
// Observes the handshakes and result register; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] estimate_o
);

  // a taken measurement keeps the core busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("core not busy after accepting a measurement");

  // a new result is only produced by a transaction in progress
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a transaction in progress");

  // the core is ready again as soon as it posts a result
  a_ready_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("core still busy after posting a result");

  // stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(estimate_o)))
    else $error("stalled result changed");

endmodule

bind scalar_kalman_filter_core skf_checker u_skf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .estimate_o  (estimate_o)
);

`default_nettype wire
